/* rtl/core/tme_pkg.sv */
`timescale 1ns / 1ps
package tme_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned IO_W           = 32;
  localparam int unsigned N_ARGS         = 9;

  // Raw action codes as they arrive on the input stream.
  localparam logic [2:0] ACT_IDENT = 3'd0;
  localparam logic [2:0] ACT_TRANS = 3'd1;
  localparam logic [2:0] ACT_SCALE = 3'd2;
  localparam logic [2:0] ACT_ROT   = 3'd3;
  localparam logic [2:0] ACT_VEC   = 3'd4;
  localparam logic [2:0] ACT_READ  = 3'd5;

  typedef enum logic [2:0] {
    K_IDENT,
    K_TRANS,
    K_SCALE,
    K_ROT,
    K_VEC,
    K_READ
  } kind_e;

  typedef struct packed {
    kind_e                             kind;
    logic [N_ARGS-1:0][IO_W-1:0]       arg;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

endpackage

/* rtl/core/tme_front.sv */
`timescale 1ns / 1ps
module tme_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_tvalid_i,
  output logic                                  s_tready_o,
  input  logic [2:0]                            s_tuser_i,
  input  logic [tme_pkg::N_ARGS*tme_pkg::IO_W-1:0] s_tdata_i,
  output tme_pkg::head_t                        head_o,
  input  logic                                  pop_i
);
  import tme_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       known;
  logic       push;
  cmd_t       cmd_in;

  always_comb begin
    known = 1'b1;
    cmd_in.arg = s_tdata_i;
    unique case (s_tuser_i)
      ACT_IDENT: cmd_in.kind = K_IDENT;
      ACT_TRANS: cmd_in.kind = K_TRANS;
      ACT_SCALE: cmd_in.kind = K_SCALE;
      ACT_ROT:   cmd_in.kind = K_ROT;
      ACT_VEC:   cmd_in.kind = K_VEC;
      ACT_READ:  cmd_in.kind = K_READ;
      default: begin
        // Unused codes are taken and dropped here.
        cmd_in.kind = K_IDENT;
        known = 1'b0;
      end
    endcase
  end

  assign s_tready_o   = (cnt_q != 2'd2);
  assign push         = s_tvalid_i && s_tready_o && known;
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.cmd   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= cmd_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end
endmodule

/* rtl/core/tme_exec.sv */
`timescale 1ns / 1ps
module tme_exec #(
  parameter int unsigned DATA_WIDTH = tme_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = tme_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tme_pkg::head_t         head_i,
  output logic                   pop_o,
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  output logic [4*tme_pkg::IO_W-1:0] m_tdata_o,
  output logic [1:0]             m_tuser_o,
  output logic                   m_tlast_o
);
  import tme_pkg::*;

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned PW = DATA_WIDTH + IO_W;
  localparam logic signed [PW-1:0] SAT_HI = $signed({{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}});
  localparam logic signed [PW-1:0] SAT_LO = $signed({{(PW-DW+1){1'b1}}, {(DW-1){1'b0}}});
  localparam logic signed [DW-1:0] MAX_V  = $signed({1'b0, {(DW-1){1'b1}}});
  localparam logic signed [DW-1:0] MIN_V  = $signed({1'b1, {(DW-1){1'b0}}});
  localparam logic signed [DW-1:0] ONE_V  =
    (FRAC_BITS + 2 <= DATA_WIDTH) ? (DW'(1) << FRAC_BITS) : MAX_V;
  localparam logic signed [PW-1:0] RND    = PW'((64'd1 << FRAC_BITS) - 64'd1);

  // Product shifted toward zero and saturated to the entry range.
  function automatic logic signed [DW-1:0] mulq(input logic signed [DW-1:0] m,
                                               input logic signed [IO_W-1:0] c);
    logic signed [PW-1:0] me, ce, p, sh;
    me = PW'(m);
    ce = PW'(c);
    p  = me * ce;
    sh = (p < 0) ? ((p + RND) >>> FRAC_BITS) : (p >>> FRAC_BITS);
    if (sh > SAT_HI) return MAX_V;
    if (sh < SAT_LO) return MIN_V;
    return sh[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] addc(input logic signed [DW-1:0] a,
                                               input logic signed [DW-1:0] b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) return s[DW] ? MIN_V : MAX_V;
    return s[DW-1:0];
  endfunction

  logic signed [DW-1:0] mat_q [4][4];
  logic signed [DW-1:0] prod_q [3][3];
  logic signed [DW-1:0] prod_d [3][3];
  logic                 pv_q;
  kind_e                pk_q;
  logic [1:0]           pc_q;
  logic [1:0]           step_q;

  logic                 iss, rd, load_id, out_free;
  logic signed [DW-1:0] sum [3];
  logic signed [DW-1:0] init0;

  logic                 ov_q, olast_q;
  logic [1:0]           orow_q;
  logic [IO_W-1:0]      oa_q, ob_q, oc_q, od_q;

  assign out_free = !ov_q || m_tready_i;

  // Sequencer: a new item starts only once the previous write-back is done.
  always_comb begin
    iss = 1'b0;
    rd = 1'b0;
    load_id = 1'b0;
    pop_o = 1'b0;
    if (head_i.valid) begin
      unique case (head_i.cmd.kind)
        K_IDENT: if (!pv_q) begin
          load_id = 1'b1;
          pop_o = 1'b1;
        end
        K_TRANS, K_SCALE, K_ROT: if (step_q != 2'd0 || !pv_q) begin
          iss = 1'b1;
          pop_o = (step_q == 2'd3);
        end
        K_VEC: if (!pv_q && out_free) begin
          iss = 1'b1;
          pop_o = 1'b1;
        end
        K_READ: if (!pv_q && out_free) begin
          rd = 1'b1;
          pop_o = (step_q == 2'd3);
        end
        default: ;
      endcase
    end
  end

  // Nine product lanes: lane [i][k] feeds output row i, term k.
  always_comb begin
    logic signed [DW-1:0]   m;
    logic signed [IO_W-1:0] c;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        unique case (head_i.cmd.kind)
          K_VEC: begin
            m = mat_q[i][k];
            c = $signed(head_i.cmd.arg[k]);
          end
          K_SCALE: begin
            m = mat_q[i][step_q];
            c = $signed(head_i.cmd.arg[i]);
          end
          K_ROT: begin
            m = mat_q[k][step_q];
            c = $signed(head_i.cmd.arg[3*i+k]);
          end
          default: begin
            m = mat_q[k][step_q];
            c = $signed(head_i.cmd.arg[k]);
          end
        endcase
        prod_d[i][k] = mulq(m, c);
      end
    end
  end

  always_comb begin
    init0 = (pk_q == K_TRANS) ? mat_q[3][pc_q] : '0;
    for (int i = 0; i < 3; i++) begin
      sum[i] = addc(addc(addc((i == 0) ? init0 : DW'(0), prod_q[i][0]),
                         prod_q[i][1]), prod_q[i][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (iss) prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++) mat_q[r][c] <= (r == c) ? ONE_V : '0;
      pv_q   <= 1'b0;
      pk_q   <= K_IDENT;
      pc_q   <= 2'd0;
      step_q <= 2'd0;
    end else begin
      pv_q <= iss;
      if (iss) begin
        pk_q <= head_i.cmd.kind;
        pc_q <= step_q;
      end
      if (pop_o) step_q <= 2'd0;
      else if (iss || rd) step_q <= step_q + 2'd1;
      if (load_id) begin
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++) mat_q[r][c] <= (r == c) ? ONE_V : '0;
      end else if (pv_q) begin
        unique case (pk_q)
          K_TRANS: mat_q[3][pc_q] <= sum[0];
          K_SCALE: for (int i = 0; i < 3; i++) mat_q[i][pc_q] <= prod_q[i][0];
          K_ROT:   for (int i = 0; i < 3; i++) mat_q[i][pc_q] <= sum[i];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (rd || (pv_q && pk_q == K_VEC)) begin
      ov_q <= 1'b1;
    end else if (m_tready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd) begin
      oa_q    <= IO_W'(mat_q[step_q][0]);
      ob_q    <= IO_W'(mat_q[step_q][1]);
      oc_q    <= IO_W'(mat_q[step_q][2]);
      od_q    <= IO_W'(mat_q[step_q][3]);
      orow_q  <= step_q;
      olast_q <= (step_q == 2'd3);
    end else if (pv_q && pk_q == K_VEC) begin
      oa_q    <= IO_W'(sum[0]);
      ob_q    <= IO_W'(sum[1]);
      oc_q    <= IO_W'(sum[2]);
      od_q    <= '0;
      orow_q  <= 2'd0;
      olast_q <= 1'b1;
    end
  end

  assign m_tvalid_o = ov_q;
  assign m_tdata_o  = {od_q, oc_q, ob_q, oa_q};
  assign m_tuser_o  = orow_q;
  assign m_tlast_o  = olast_q;
endmodule

/* rtl/core/transform_matrix_engine.sv */
`timescale 1ns / 1ps
// Matrix updates take 4 column passes plus one write-back;
// identity loads directly, a vector transform is one product pass, a readout 4 beats.
// A vector goes from the queue head through the product register to the output register.
// The rate is set by the column sequencer sharing the nine product lanes.
// Reset (rst_ni low, asynchronous) loads identity and empties the queue and output.
module transform_matrix_engine #(
  parameter int unsigned DATA_WIDTH = tme_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = tme_pkg::FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid,
  output logic         s_tready,
  // action[2:0]
  input  logic [2:0]   s_tuser,
  // arg_0, arg_1, ..., arg_8, 32 bits each from the lowest bit up
  input  logic [287:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_a, out_b, out_c, out_d, 32 bits each from the lowest bit up
  output logic [127:0] m_tdata,
  // row_index[1:0]
  output logic [1:0]   m_tuser,
  output logic         m_tlast
);
  import tme_pkg::*;

  head_t head;
  logic  pop;

  tme_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .s_tuser_i  (s_tuser),
    .s_tdata_i  (s_tdata),
    .head_o     (head),
    .pop_i      (pop)
  );

  tme_exec #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_exec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .pop_o      (pop),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata),
    .m_tuser_o  (m_tuser),
    .m_tlast_o  (m_tlast)
  );
endmodule

/* dv/tb_transform_matrix_engine.sv */
`timescale 1ns / 1ps
module tb_transform_matrix_engine;
  import tme_pkg::*;

  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;
  localparam longint ONE  = 64'sd65536;

  typedef struct {
    logic [31:0] a, b, c, d;
    logic [1:0]  row;
    logic        last;
  } beat_t;

  class matrix_scoreboard;
    longint  m [16];
    beat_t   pending[$];
    int      errors;

    function new();
      load_identity();
      errors = 0;
    endfunction

    function void load_identity();
      for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? ONE : 0;
    endfunction

    function longint sat(longint v);
      if (v > QMAX) return QMAX;
      if (v < QMIN) return QMIN;
      return v;
    endfunction

    // Entries stay within 32 bits, so the exact product fits in 64 bits.
    function longint qmul(longint x, longint y);
      longint p;
      p = x * y;
      p = (p < 0) ? -((-p) >>> 16) : (p >>> 16);
      return sat(p);
    endfunction

    function void push(longint a, longint b, longint c, longint d, int r, bit l);
      beat_t e;
      e.a = a[31:0]; e.b = b[31:0]; e.c = c[31:0]; e.d = d[31:0];
      e.row = r[1:0]; e.last = l;
      pending.push_back(e);
    endfunction

    function void note_item(logic [2:0] act, logic [287:0] data);
      longint x[9];
      longint t[12];
      longint s;
      for (int i = 0; i < 9; i++) x[i] = longint'(signed'(data[32*i +: 32]));
      case (act)
        ACT_IDENT: load_identity();
        ACT_TRANS: begin
          for (int j = 0; j < 4; j++) begin
            s = m[12+j];
            for (int k = 0; k < 3; k++) s = sat(s + qmul(m[4*k+j], x[k]));
            m[12+j] = s;
          end
        end
        ACT_SCALE: begin
          for (int i = 0; i < 3; i++)
            for (int j = 0; j < 4; j++) m[4*i+j] = qmul(m[4*i+j], x[i]);
        end
        ACT_ROT: begin
          for (int i = 0; i < 3; i++)
            for (int j = 0; j < 4; j++) begin
              s = 0;
              for (int k = 0; k < 3; k++) s = sat(s + qmul(m[4*k+j], x[3*i+k]));
              t[4*i+j] = s;
            end
          for (int i = 0; i < 12; i++) m[i] = t[i];
        end
        ACT_VEC: begin
          for (int i = 0; i < 3; i++) begin
            s = 0;
            for (int k = 0; k < 3; k++) s = sat(s + qmul(m[4*i+k], x[k]));
            t[i] = s;
          end
          push(t[0], t[1], t[2], 0, 0, 1'b1);
        end
        ACT_READ: begin
          for (int i = 0; i < 4; i++)
            push(m[4*i], m[4*i+1], m[4*i+2], m[4*i+3], i, i == 3);
        end
        default: ;
      endcase
    endfunction

    function void check_beat(logic [127:0] data, logic [1:0] row, logic last);
      beat_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output beat %h", data);
        return;
      end
      e = pending.pop_front();
      if (data !== {e.d, e.c, e.b, e.a} || row !== e.row || last !== e.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp %h row %0d last %0b, got %h row %0d last %0b",
                   {e.d, e.c, e.b, e.a}, e.row, e.last, data, row, last);
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [2:0]   s_tuser = '0;
  logic [287:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;

  matrix_scoreboard sb = new();
  bit calm = 1'b0;

  transform_matrix_engine u_top (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (s_tvalid && s_tready) sb.note_item(s_tuser, s_tdata);
    if (m_tvalid && m_tready) sb.check_beat(m_tdata, m_tuser, m_tlast);
  end

  always @(negedge clk_i) begin
    if (rst_ni) m_tready <= calm || ($urandom_range(99) >= 27);
  end

  function automatic logic [31:0] rand_arg(bit tame);
    case ($urandom_range(tame ? 5 : 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0001_0000;
      3: return 32'hffff_0000;
      4: return $urandom_range(131072) - 65536;
      5: return $urandom_range(8191) - 4096 + (($urandom_range(3) - 1) << 16);
      default: return $urandom;
    endcase
  endfunction

  // Valid stays high after an accepted beat until the next idle cycle or the next beat.
  task automatic send_item(logic [2:0] act, logic [287:0] data);
    while (!calm && $urandom_range(99) < 27) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= data;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random(bit tame);
    logic [287:0] d;
    logic [2:0] act;
    for (int i = 0; i < 9; i++) d[32*i +: 32] = rand_arg(tame);
    act = $urandom_range(99) < 3 ? 3'($urandom_range(7)) : 3'($urandom_range(5));
    if (!tame && $urandom_range(3) == 0) act = ACT_READ;
    send_item(act, d);
  endtask

  initial begin
    logic [287:0] d;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: each action, extreme values, saturation, unused codes.
    d = '0;
    send_item(ACT_READ, d);
    d = {9{32'h0002_0000}};
    send_item(ACT_VEC, {d[287:96], 32'h8000_0000, 32'h7fff_ffff, 32'h0001_8000});
    send_item(ACT_TRANS, {d[287:96], 32'hffff_8000, 32'h0003_0000, 32'h0001_0000});
    send_item(ACT_READ, d);
    send_item(ACT_SCALE, {d[287:96], 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000});
    send_item(ACT_READ, d);
    send_item(ACT_VEC, {d[287:96], 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
    send_item(ACT_ROT, {9{32'h8000_0000}});
    send_item(ACT_READ, d);
    send_item(ACT_TRANS, {9{32'h7fff_ffff}});
    send_item(ACT_READ, d);
    send_item(3'd6, {9{32'hffff_ffff}});
    send_item(3'd7, {9{32'hffff_ffff}});
    send_item(ACT_READ, d);
    send_item(ACT_IDENT, {9{32'ha5a5_5a5a}});
    send_item(ACT_ROT, {32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'hffff_0000,
                        32'h0, 32'h0001_0000, 32'h0});
    send_item(ACT_READ, d);
    send_item(ACT_VEC, {d[287:96], 32'h0000_0001, 32'hffff_ffff, 32'h0001_0000});

    for (int n = 0; n < 500; n++) begin
      calm = (n >= 200 && n < 260);
      if (n == 300) begin
        s_tvalid <= 1'b0;
        @(negedge clk_i);
        while (sb.pending.size() != 0) @(negedge clk_i);
      end
      if (n % 60 == 0) send_item(ACT_IDENT, {9{32'($urandom)}});
      send_random(n % 3 != 0);
    end
    calm = 1'b0;
    s_tvalid <= 1'b0;
    @(negedge clk_i);

    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
